FILE: rtl/core/lkcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lkcc_pkg;

  localparam int HUE_W    = 9;
  localparam int LVL_W    = 7;
  localparam int CH_W     = 8;
  localparam int T_W      = 6;
  localparam int PROD_W   = 21;
  localparam int REM_W    = 13;
  localparam int CNT_W    = 5;

  localparam logic [9:0]        HUE_MOD    = 10'd360;
  localparam logic [HUE_W-1:0]  SECTOR_DEG = 9'd60;
  localparam logic [LVL_W-1:0]  LVL_MAX    = 7'd100;
  localparam logic [REM_W:0]    DIVISOR    = 14'd6000;
  localparam logic [T_W-1:0]    T_FULL     = 6'd60;
  localparam logic [CH_W-1:0]   STRIP_LOW  = 8'hFF;
  localparam logic [CNT_W-1:0]  MUL_LAST   = 5'd5;
  localparam logic [CNT_W-1:0]  DIV_LAST   = 5'd20;

  localparam logic [1:0] FUNC_COLOR_STEP = 2'd0;
  localparam logic [1:0] FUNC_COLOR_BTN  = 2'd1;
  localparam logic [1:0] FUNC_POWER_STEP = 2'd2;
  localparam logic [1:0] FUNC_POWER_BTN  = 2'd3;

  localparam logic [1:0] REG_HUE_STEP = 2'd0;
  localparam logic [1:0] REG_LVL_STEP = 2'd1;

  typedef logic [2:0] sector_t;

endpackage

`default_nettype wire

FILE: rtl/core/led_knob_color_controller.sv
// A request is accepted only while idle; it makes one pass in white mode and two
// passes in color mode, each a bit-serial multiply followed by a restoring divide
// by 6000. A new request is stalled until the previous one is done; a waiting
// result does not block the next request.
// Reset (rst_n low, synchronous): hue 0, level 0, white mode on, steps 2 and 5.
`timescale 1ns / 1ps
`default_nettype none

module led_knob_color_controller
  import lkcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_func,
  input  wire logic             in_other_phase,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic [31:0]           out_strip_word,
  output logic [HUE_W-1:0]      out_hue_now,
  output logic [LVL_W-1:0]      out_level_now,
  output logic                  out_white_now
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_t;

  state_t              state_r;
  logic                pass_r;
  logic [7:0]          hue_step_r;
  logic [LVL_W-1:0]    lvl_step_r;
  logic [HUE_W-1:0]    hue_r;
  logic [LVL_W-1:0]    lvl_r;
  logic                white_r;
  logic [T_W-1:0]      t_sh_r;
  logic [PROD_W-1:0]   m_sh_r;
  logic [PROD_W-1:0]   acc_r;
  logic [REM_W-1:0]    rem_r;
  logic [CH_W-1:0]     q_r;
  logic [CH_W-1:0]     v_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [CH_W-1:0]     red_r, green_r, blue_r;
  logic [HUE_W-1:0]    hue_out_r;
  logic [LVL_W-1:0]    lvl_out_r;
  logic                white_out_r;

  logic [HUE_W-1:0]    hue_nxt;
  logic [LVL_W-1:0]    lvl_nxt;
  logic                white_nxt;
  logic [9:0]          hue_up, hue_dn;
  logic [LVL_W:0]      lvl_up;
  logic                accept;
  sector_t             sector;
  logic [HUE_W-1:0]    sec_base;
  logic [T_W-1:0]      f_deg, t_deg;
  logic [REM_W:0]      rem_try;
  logic                q_bit;
  logic [CH_W-1:0]     q_nxt;
  logic [PROD_W-1:0]   acc_add;
  logic [CH_W-1:0]     x_val;
  logic [CH_W-1:0]     r_sel, g_sel, b_sel;
  logic                out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    hue_up    = {1'b0, hue_r} + {2'b00, hue_step_r};
    hue_dn    = (hue_r >= {1'b0, hue_step_r}) ? ({1'b0, hue_r} - {2'b00, hue_step_r})
                                               : ({1'b0, hue_r} + HUE_MOD - {2'b00, hue_step_r});
    lvl_up    = {1'b0, lvl_r} + {1'b0, lvl_step_r};
    hue_nxt   = hue_r;
    lvl_nxt   = lvl_r;
    white_nxt = white_r;
    unique case (in_func)
      FUNC_COLOR_STEP: begin
        white_nxt = 1'b0;
        if (in_other_phase) begin
          hue_nxt = (hue_up >= HUE_MOD) ? 9'(hue_up - HUE_MOD) : hue_up[HUE_W-1:0];
        end else begin
          hue_nxt = hue_dn[HUE_W-1:0];
        end
      end
      FUNC_COLOR_BTN: white_nxt = !white_r;
      FUNC_POWER_STEP: begin
        if (in_other_phase) begin
          lvl_nxt = (lvl_up > {1'b0, LVL_MAX}) ? LVL_MAX : lvl_up[LVL_W-1:0];
        end else begin
          lvl_nxt = (lvl_r > lvl_step_r) ? (lvl_r - lvl_step_r) : '0;
        end
      end
      default: lvl_nxt = (lvl_r != '0) ? '0 : LVL_MAX;
    endcase
  end

  always_comb begin
    if (hue_r >= 5 * SECTOR_DEG) begin
      sector = 3'd5;
    end else if (hue_r >= 4 * SECTOR_DEG) begin
      sector = 3'd4;
    end else if (hue_r >= 3 * SECTOR_DEG) begin
      sector = 3'd3;
    end else if (hue_r >= 2 * SECTOR_DEG) begin
      sector = 3'd2;
    end else if (hue_r >= SECTOR_DEG) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
    sec_base = 9'(sector * SECTOR_DEG);
    f_deg    = 6'(hue_r - sec_base);
    t_deg    = sector[0] ? (T_FULL - f_deg) : f_deg;
  end

  always_comb begin
    acc_add = t_sh_r[0] ? (acc_r + m_sh_r) : acc_r;
    rem_try = {rem_r, acc_r[PROD_W-1]};
    q_bit   = (rem_try >= DIVISOR);
    q_nxt   = {q_r[CH_W-2:0], q_bit};
  end

  always_comb begin
    x_val = q_r;
    r_sel = v_r;
    g_sel = v_r;
    b_sel = v_r;
    if (!white_r) begin
      case (sector)
        3'd0:    begin r_sel = v_r;   g_sel = x_val; b_sel = '0;    end
        3'd1:    begin r_sel = x_val; g_sel = v_r;   b_sel = '0;    end
        3'd2:    begin r_sel = '0;    g_sel = v_r;   b_sel = x_val; end
        3'd3:    begin r_sel = '0;    g_sel = x_val; b_sel = v_r;   end
        3'd4:    begin r_sel = x_val; g_sel = '0;    b_sel = v_r;   end
        default: begin r_sel = v_r;   g_sel = '0;    b_sel = x_val; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= 1'b0;
      hue_step_r  <= 8'd2;
      lvl_step_r  <= 7'd5;
      hue_r       <= '0;
      lvl_r       <= '0;
      white_r     <= 1'b1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HUE_STEP: hue_step_r <= cfg_wdata;
          REG_LVL_STEP: lvl_step_r <= cfg_wdata[LVL_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            hue_r   <= hue_nxt;
            lvl_r   <= lvl_nxt;
            white_r <= white_nxt;
            m_sh_r  <= PROD_W'({lvl_nxt, 8'd0} - {8'd0, lvl_nxt});
            t_sh_r  <= T_FULL;
            acc_r   <= '0;
            cnt_r   <= MUL_LAST;
            pass_r  <= 1'b0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r  <= acc_add;
          m_sh_r <= {m_sh_r[PROD_W-2:0], 1'b0};
          t_sh_r <= {1'b0, t_sh_r[T_W-1:1]};
          if (cnt_r == '0) begin
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= DIV_LAST;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_DIV: begin
          rem_r <= q_bit ? REM_W'(rem_try - DIVISOR) : rem_try[REM_W-1:0];
          q_r   <= q_nxt;
          if (cnt_r != '0) begin
            acc_r <= {acc_r[PROD_W-2:0], 1'b0};
            cnt_r <= cnt_r - 1'b1;
          end else if (pass_r || white_r) begin
            if (!pass_r) begin
              v_r <= q_nxt;
            end
            state_r <= S_DONE;
          end else begin
            v_r     <= q_nxt;
            m_sh_r  <= PROD_W'({lvl_r, 8'd0} - {8'd0, lvl_r});
            t_sh_r  <= t_deg;
            acc_r   <= '0;
            cnt_r   <= MUL_LAST;
            pass_r  <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          if (out_free) begin
            red_r       <= r_sel;
            green_r     <= g_sel;
            blue_r      <= b_sel;
            hue_out_r   <= hue_r;
            lvl_out_r   <= lvl_r;
            white_out_r <= white_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_strip_word = {red_r, green_r, blue_r, STRIP_LOW};
  assign out_hue_now    = hue_out_r;
  assign out_level_now  = lvl_out_r;
  assign out_white_now  = white_out_r;

`ifndef SYNTHESIS
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("request accepted but input not stalled");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level_now <= LVL_MAX))
    else $error("level out of range");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_hue_now} < HUE_MOD))
    else $error("hue out of range");

  a_white_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_white_now) |-> (out_red == out_green && out_green == out_blue))
    else $error("white mode result is not gray");
`endif

endmodule

`default_nettype wire
